[rtl/kmp_pkg.sv]
// kmp_pkg: shared constants and types of the keyframe motion player
package kmp_pkg;

   localparam logic [2:0] OP_WRITE_FRAME = 3'd0;
   localparam logic [2:0] OP_WRITE_TRACK = 3'd1;
   localparam logic [2:0] OP_START       = 3'd2;
   localparam logic [2:0] OP_CLEAR       = 3'd3;
   localparam logic [2:0] OP_TICK        = 3'd4;

   localparam logic [1:0] MODE_LOOP = 2'd0;
   localparam logic [1:0] MODE_STOP = 2'd1;

   localparam int DUR_W   = 15;
   localparam int MOVE_W  = 16;
   localparam int STEP_W  = 24;
   localparam int FRAME_W = 11;
   localparam int TICKS_W = 16;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_TRK  = 7'b0000010,
      S_REC1 = 7'b0000100,
      S_REC2 = 7'b0001000,
      S_DX   = 7'b0010000,
      S_DY   = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

endpackage

[rtl/kmp_div.sv]
// kmp_div: shared restoring divider, one quotient bit per cycle
module kmp_div #(
   parameter int NW = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NW-1:0]               num,
   input  logic [kmp_pkg::DUR_W-1:0]   den,
   output logic                        done,
   output logic [NW-1:0]               quot
);

   localparam int CW = $clog2(NW + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [kmp_pkg::DUR_W:0]     rem_ff, rem_in;
   logic [NW-1:0]               q_ff, q_in;
   logic [kmp_pkg::DUR_W-1:0]   den_ff, den_in;
   logic [kmp_pkg::DUR_W:0]     rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[kmp_pkg::DUR_W-1:0], q_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[rtl/keyframe_motion_player_top.sv]
// keyframe_motion_player_top: channel state, track and frame stores, tick sequencer
//
//   channel  direction  handshake             content
//   req_     in         req_valid/req_ready   store writes, start, clear, tick
//   rsp_     out        rsp_valid/rsp_ready   object, x and y step, frame, running
//
// writes, start, clear and ticks giving no result leave the sequencer idle
// a tick with a result steps through TRK, REC1, REC2, DX and DY, making two passes
// of the one bit per cycle divider, then holds its result in OUT until rsp_ready
// reset clears all channel state; frame and track stores are not cleared
// req_ready is low from a resulting tick's acceptance until its result is taken
module keyframe_motion_player_top #(
   parameter int CHANNELS    = 16,
   parameter int FRAME_DEPTH = 1024,
   parameter int TRACK_DEPTH = 64,
   parameter int FRAC_BITS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [3:0]         req_channel,
   input  logic [9:0]         req_object_id,
   input  logic [5:0]         req_track,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_frame_index,
   input  logic signed [15:0] req_move_x,
   input  logic signed [15:0] req_move_y,
   input  logic [14:0]        req_duration,
   input  logic [10:0]        req_frame_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_object_id_out,
   output logic signed [23:0] rsp_step_x,
   output logic signed [23:0] rsp_step_y,
   output logic [9:0]         rsp_frame_now,
   output logic               rsp_still_running
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FA_W = $clog2(FRAME_DEPTH);
   localparam int TA_W = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
   localparam int NW   = kmp_pkg::MOVE_W + FRAC_BITS;
   localparam int REC_W = 2 * kmp_pkg::MOVE_W + kmp_pkg::DUR_W;

   function automatic logic [FA_W-1:0] frame_mod(input logic [11:0] s);
      logic [23:0] v;
      v = 24'(s);
      for (int k = 7; k >= 0; k--) begin
         if (v >= (24'(FRAME_DEPTH) << k)) v = v - (24'(FRAME_DEPTH) << k);
      end
      return FA_W'(v);
   endfunction

   function automatic logic [23:0] step_sat(input logic neg, input logic [NW-1:0] mag);
      logic [39:0] m;
      m = 40'(mag);
      if (neg) begin
         if (m > 40'd8388608) return 24'h800000;
         return ~m[23:0] + 24'd1;
      end
      if (m > 40'd8388607) return 24'h7FFFFF;
      return m[23:0];
   endfunction

   kmp_pkg::state_type state_ff, state_in;

   logic [CHANNELS-1:0]        act_ff, run_ff;
   logic [1:0]                 mode_ff  [CHANNELS];
   logic [kmp_pkg::FRAME_W-1:0] frame_ff [CHANNELS];
   logic [kmp_pkg::TICKS_W-1:0] ticks_ff [CHANNELS];
   logic [9:0]                 obj_ff   [CHANNELS];
   logic [TA_W-1:0]            trk_ff   [CHANNELS];

   logic [REC_W-1:0] frame_mem [FRAME_DEPTH];
   logic [20:0]      track_mem [TRACK_DEPTH];
   logic [REC_W-1:0] rec_ff;
   logic [20:0]      tdat_ff;

   logic [CH_W-1:0]  ch_ff;
   logic [kmp_pkg::FRAME_W-1:0] rd_ff, rd_in;
   logic             running_ff, running_in;
   logic [NW-1:0]    qx_ff;

   logic [CH_W-1:0]  ch_idx;
   logic             ch_ok, accept, is_op_tick;
   logic             fmem_rd;
   logic [FA_W-1:0]  fmem_addr;

   logic [9:0]                  t_first;
   logic [kmp_pkg::FRAME_W-1:0] t_len, fr_cur, fr_next;
   logic [kmp_pkg::DUR_W-1:0]   r_dur;
   logic signed [15:0]          r_mx, r_my;
   logic [kmp_pkg::TICKS_W-1:0] tk_base, tk_new;
   logic                        adv;

   logic             div_start, div_done;
   logic [NW-1:0]    div_num, div_quot;
   logic [NW-1:0]    mag_x, mag_y;

   logic             rv_ff;
   logic [9:0]       o_obj_ff;
   logic [23:0]      o_sx_ff, o_sy_ff;
   logic [9:0]       o_fr_ff;
   logic             o_run_ff;

   assign ch_idx     = CH_W'(req_channel);
   assign ch_ok      = 32'(req_channel) < CHANNELS;
   assign req_ready  = state_ff == kmp_pkg::S_IDLE;
   assign accept     = req_valid && req_ready;
   assign is_op_tick = req_operation == kmp_pkg::OP_TICK;

   assign t_first = tdat_ff[20:11];
   assign t_len   = tdat_ff[10:0];
   assign r_mx    = rec_ff[REC_W-1 -: 16];
   assign r_my    = rec_ff[kmp_pkg::DUR_W +: 16];
   assign r_dur   = rec_ff[kmp_pkg::DUR_W-1:0];
   assign fr_cur  = frame_ff[ch_ff];

   assign mag_x = r_mx[15] ? NW'(-(17'(r_mx))) << FRAC_BITS : NW'(r_mx) << FRAC_BITS;
   assign mag_y = r_my[15] ? NW'(-(17'(r_my))) << FRAC_BITS : NW'(r_my) << FRAC_BITS;

   // tick update
   always_comb begin
      adv        = ticks_ff[ch_ff] >= {1'b0, r_dur};
      fr_next    = fr_cur;
      running_in = 1'b1;
      tk_base    = adv ? '0 : ticks_ff[ch_ff];
      tk_new     = (tk_base == '1) ? tk_base : tk_base + 1'b1;
      if (adv) begin
         fr_next = fr_cur + 1'b1;
         if (fr_next >= t_len) begin
            if (mode_ff[ch_ff] == kmp_pkg::MODE_LOOP) begin
               fr_next = '0;
            end else if (mode_ff[ch_ff] == kmp_pkg::MODE_STOP) begin
               running_in = 1'b0;
               fr_next    = (t_len != '0) ? t_len - 1'b1 : '0;
            end else begin
               running_in = 1'b0;
            end
         end
      end
      rd_in = (fr_next >= t_len) ? ((t_len != '0) ? t_len - 1'b1 : '0) : fr_next;
   end

   always_comb begin
      fmem_rd   = 1'b0;
      fmem_addr = frame_mod(12'(t_first) + 12'(fr_cur));
      if (state_ff == kmp_pkg::S_TRK) begin
         fmem_rd = 1'b1;
      end else if (state_ff == kmp_pkg::S_REC1) begin
         fmem_rd   = 1'b1;
         fmem_addr = frame_mod(12'(t_first) + 12'(rd_in));
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = mag_x;
      case (state_ff)
         kmp_pkg::S_IDLE: begin
            if (accept && is_op_tick && ch_ok && act_ff[ch_idx] && run_ff[ch_idx]) begin
               state_in = kmp_pkg::S_TRK;
            end
         end
         kmp_pkg::S_TRK:  state_in = kmp_pkg::S_REC1;
         kmp_pkg::S_REC1: state_in = kmp_pkg::S_REC2;
         kmp_pkg::S_REC2: begin
            div_start = 1'b1;
            state_in  = kmp_pkg::S_DX;
         end
         kmp_pkg::S_DX: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = mag_y;
               state_in  = kmp_pkg::S_DY;
            end
         end
         kmp_pkg::S_DY: begin
            if (div_done) state_in = kmp_pkg::S_OUT;
         end
         kmp_pkg::S_OUT: begin
            if (rsp_ready) state_in = kmp_pkg::S_IDLE;
         end
         default: state_in = kmp_pkg::S_IDLE;
      endcase
   end

   kmp_div #(.NW(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (r_dur),
      .done  (div_done),
      .quot  (div_quot)
   );

   // stores
   always_ff @(posedge clock) begin
      if (accept && req_operation == kmp_pkg::OP_WRITE_FRAME &&
          32'(req_frame_index) < FRAME_DEPTH) begin
         frame_mem[FA_W'(req_frame_index)] <= {req_move_x, req_move_y, req_duration};
      end
      if (fmem_rd) rec_ff <= frame_mem[fmem_addr];
      if (accept && req_operation == kmp_pkg::OP_WRITE_TRACK &&
          32'(req_track) < TRACK_DEPTH) begin
         track_mem[TA_W'(req_track)] <= {req_frame_index, req_frame_count};
      end
      if (accept) tdat_ff <= track_mem[trk_ff[ch_idx]];
   end

   // channel state and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmp_pkg::S_IDLE;
         act_ff   <= '0;
         run_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]  <= '0;
            frame_ff[i] <= '0;
            ticks_ff[i] <= '0;
            obj_ff[i]   <= '0;
            trk_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (accept && ch_ok && req_operation == kmp_pkg::OP_START &&
             32'(req_track) < TRACK_DEPTH) begin
            act_ff[ch_idx]   <= 1'b1;
            run_ff[ch_idx]   <= 1'b1;
            mode_ff[ch_idx]  <= req_mode;
            frame_ff[ch_idx] <= '0;
            ticks_ff[ch_idx] <= '0;
            obj_ff[ch_idx]   <= req_object_id;
            trk_ff[ch_idx]   <= TA_W'(req_track);
         end
         if (accept && ch_ok && req_operation == kmp_pkg::OP_CLEAR) begin
            act_ff[ch_idx]   <= 1'b0;
            run_ff[ch_idx]   <= 1'b0;
            frame_ff[ch_idx] <= '0;
            ticks_ff[ch_idx] <= '0;
            obj_ff[ch_idx]   <= '0;
         end
         if (state_ff == kmp_pkg::S_REC1) begin
            run_ff[ch_ff]   <= running_in;
            frame_ff[ch_ff] <= fr_next;
            ticks_ff[ch_ff] <= tk_new;
         end
         if (state_ff == kmp_pkg::S_DY && div_done) rv_ff <= 1'b1;
         else if (rv_ff && rsp_ready) rv_ff <= 1'b0;
      end
      if (accept) ch_ff <= ch_idx;
      if (state_ff == kmp_pkg::S_REC1) begin
         rd_ff      <= rd_in;
         running_ff <= running_in;
      end
      if (state_ff == kmp_pkg::S_DX && div_done) qx_ff <= div_quot;
      if (state_ff == kmp_pkg::S_DY && div_done) begin
         o_obj_ff <= obj_ff[ch_ff];
         o_sx_ff  <= (r_dur == '0) ? '0 : step_sat(r_mx[15], qx_ff);
         o_sy_ff  <= (r_dur == '0) ? '0 : step_sat(r_my[15], div_quot);
         o_fr_ff  <= rd_ff[9:0];
         o_run_ff <= running_ff;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_object_id_out = o_obj_ff;
   assign rsp_step_x        = o_sx_ff;
   assign rsp_step_y        = o_sy_ff;
   assign rsp_frame_now     = o_fr_ff;
   assign rsp_still_running = o_run_ff;

endmodule
